>>> hw/rtl/wsps_pkg.sv
// Shared types, constants and the byte-order decode for the pixel serializer.
// No dependencies; imported by every module of the block.
package wsps_pkg;

   localparam int BITS_PER_COLOR   = 8;
   localparam int COLORS           = 3;
   localparam int PIXEL_BITS       = BITS_PER_COLOR * COLORS;
   localparam int PHASES_PER_PIXEL = 2 * PIXEL_BITS;
   localparam int PHASE_IDX_W      = $clog2(PHASES_PER_PIXEL + 1);

   localparam int TICK_W    = 16;
   localparam int PULSE_W   = 12;
   localparam int CSR_IDX_W = 3;

   localparam logic [PHASE_IDX_W-1:0] LAST_BIT_PHASE =
      PHASE_IDX_W'(PHASES_PER_PIXEL - 1);
   localparam logic [PHASE_IDX_W-1:0] LATCH_PHASE = PHASE_IDX_W'(PHASES_PER_PIXEL);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_TICKS = 3'd0,
      CSR_LONG_TICKS  = 3'd1,
      CSR_LATCH_TICKS = 3'd2,
      CSR_BLUE_FIRST  = 3'd3,
      CSR_PAD_LEADS   = 3'd4
   } csr_index_type;

   // Effective settings: tick counts already forced to at least one.
   typedef struct packed {
      logic [TICK_W-1:0] short_ticks;
      logic [TICK_W-1:0] long_ticks;
      logic [TICK_W-1:0] latch_ticks;
      logic              blue_first;
      logic              pad_leads;
   } cfg_type;

   typedef struct packed {
      logic              line_level;
      logic [TICK_W-1:0] phase_ticks;
      logic              final_phase;
   } phase_type;

   // Pick the three color bytes and return them in wire order: green, red, blue.
   function automatic logic [PIXEL_BITS-1:0] decode_grb(
      input logic [31:0] word,
      input logic        pad_leads,
      input logic        blue_first
   );
      logic [23:0] colors;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      colors = pad_leads ? word[31:8] : word[23:0];
      green  = colors[15:8];
      if (blue_first) begin
         blue = colors[7:0];
         red  = colors[23:16];
      end else begin
         red  = colors[7:0];
         blue = colors[23:16];
      end
      return {green, red, blue};
   endfunction

endpackage

>>> hw/rtl/wsps_csr_regs.sv
// Configuration registers of the pixel serializer and their effective values.
// Depends on wsps_pkg.
module wsps_csr_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [wsps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wsps_pkg::TICK_W-1:0]    csr_wdata,
   output wsps_pkg::cfg_type              cfg
);
   import wsps_pkg::*;

   logic [PULSE_W-1:0] short_ff;
   logic [PULSE_W-1:0] long_ff;
   logic [TICK_W-1:0]  latch_ff;
   logic               blue_first_ff;
   logic               pad_leads_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff      <= PULSE_W'(20);
         long_ff       <= PULSE_W'(45);
         latch_ff      <= TICK_W'(2500);
         blue_first_ff <= 1'b0;
         pad_leads_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHORT_TICKS: short_ff      <= csr_wdata[PULSE_W-1:0];
            CSR_LONG_TICKS:  long_ff       <= csr_wdata[PULSE_W-1:0];
            CSR_LATCH_TICKS: latch_ff      <= csr_wdata;
            CSR_BLUE_FIRST:  blue_first_ff <= csr_wdata[0];
            CSR_PAD_LEADS:   pad_leads_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A zero count still holds the line for one tick.
   always_comb begin
      cfg.short_ticks = (short_ff == '0) ? TICK_W'(1) : TICK_W'(short_ff);
      cfg.long_ticks  = (long_ff == '0) ? TICK_W'(1) : TICK_W'(long_ff);
      cfg.latch_ticks = (latch_ff == '0) ? TICK_W'(1) : latch_ff;
      cfg.blue_first  = blue_first_ff;
      cfg.pad_leads   = pad_leads_ff;
   end

endmodule

>>> hw/rtl/wsps_phase_seq.sv
// Pixel input register and phase sequencer: holds one pixel in wire order and
// steps through its bit phases and optional latch phase. Depends on wsps_pkg.
module wsps_phase_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  wsps_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_pixel_word,
   input  logic                 req_last_pixel,
   input  logic                 advance,
   output logic                 phase_valid,
   output wsps_pkg::phase_type  phase
);
   import wsps_pkg::*;

   logic                   busy_ff;
   logic                   busy_in;
   logic [PIXEL_BITS-1:0]  bits_ff;
   logic [PIXEL_BITS-1:0]  bits_in;
   logic                   last_ff;
   logic [PHASE_IDX_W-1:0] idx_ff;
   logic [PHASE_IDX_W-1:0] idx_in;
   logic                   latch_phase;
   logic                   cur_bit;
   logic                   take;
   logic                   step;

   assign latch_phase = (idx_ff == LATCH_PHASE);
   assign cur_bit     = bits_ff[PIXEL_BITS-1];

   always_comb begin
      phase.line_level  = ~idx_ff[0] & ~latch_phase;
      phase.phase_ticks = latch_phase ? cfg.latch_ticks :
                          (cur_bit ^ idx_ff[0]) ? cfg.long_ticks : cfg.short_ticks;
      phase.final_phase = latch_phase | ((idx_ff == LAST_BIT_PHASE) & ~last_ff);
   end

   assign phase_valid = busy_ff;
   assign step        = busy_ff & advance;
   assign req_ready   = ~busy_ff | (step & phase.final_phase);
   assign take        = req_valid & req_ready;

   always_comb begin
      busy_in = busy_ff;
      bits_in = bits_ff;
      idx_in  = idx_ff;
      if (step) begin
         idx_in = idx_ff + PHASE_IDX_W'(1);
         // shift to the next bit after its low phase
         if (idx_ff[0]) begin
            bits_in = {bits_ff[PIXEL_BITS-2:0], 1'b0};
         end
         if (phase.final_phase) begin
            busy_in = 1'b0;
         end
      end
      if (take) begin
         busy_in = 1'b1;
         bits_in = decode_grb(req_pixel_word, cfg.pad_leads, cfg.blue_first);
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      if (take) begin
         last_ff <= req_last_pixel;
      end
   end

endmodule

>>> hw/rtl/ws2812_pixel_serializer.sv
// Top level of the LED pixel serializer: configuration registers, phase
// sequencer and the registered result stage. Depends on wsps_pkg,
// wsps_csr_regs and wsps_phase_seq.
//
// Usage:
//  - req_ channel: one transfer carries a 32-bit pixel word (byte 0 in bits
//    7:0) and a last-pixel flag. Each pixel turns into 48 line phases (a high
//    and a low phase per color bit, green, red, blue, MSB first), plus one
//    low latch phase when the last-pixel flag is set.
//  - rsp_ channel: one transfer per phase: line level, tick count and a flag
//    on the last phase of the pixel.
//  - csr_ port: write-only, index 0..4 = short, long, latch ticks, blue_first,
//    pad_leads. Write only while no pixel is in flight. A zero tick count
//    acts as one tick; writes to other indexes are dropped.
// Timing: a pixel's first phase reaches rsp_ after the pixel register and the
// result register. Phases leave one per cycle while rsp_ready is high; a
// pixel is 48 or 49 phases, and the next is taken in the same cycle its final
// phase enters the result register, so a stream keeps the output gap-free.
// Reset clears the pipeline and loads the default register values.
// A stalled receiver (rsp_ready low) holds the result register and freezes
// the sequencer; no phase is lost or repeated.
module ws2812_pixel_serializer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [31:0]                    req_pixel_word,
   input  logic                           req_last_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_line_level,
   output logic [wsps_pkg::TICK_W-1:0]    rsp_phase_ticks,
   output logic                           rsp_final_phase,
   input  logic                           csr_we,
   input  logic [wsps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wsps_pkg::TICK_W-1:0]    csr_wdata
);
   import wsps_pkg::*;

   cfg_type   cfg;
   phase_type phase;
   logic      phase_valid;
   logic      advance;
   logic      out_valid_ff;
   logic      out_valid_in;
   phase_type out_ff;

   wsps_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wsps_phase_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_word (req_pixel_word),
      .req_last_pixel (req_last_pixel),
      .advance        (advance),
      .phase_valid    (phase_valid),
      .phase          (phase)
   );

   // Advance whenever the result register is empty or being drained.
   assign advance      = ~out_valid_ff | rsp_ready;
   assign out_valid_in = advance ? phase_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: load a new phase on advance, hold otherwise.
   always_ff @(posedge clock) begin
      if (advance & phase_valid) begin
         out_ff <= phase;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_line_level  = out_ff.line_level;
   assign rsp_phase_ticks = out_ff.phase_ticks;
   assign rsp_final_phase = out_ff.final_phase;

endmodule
